@@ hw/rtl/follow_target_velocity_law_defines.svh @@
// Assertion macros for the follow target velocity law block.
`ifndef FOLLOW_TARGET_VELOCITY_LAW_DEFINES_SVH
`define FOLLOW_TARGET_VELOCITY_LAW_DEFINES_SVH

`ifndef ASSERT_OFF

// Plain property, sampled on clk, off while rst_n is low.
`define FVL_ASSERT(label, prop) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
        else $error("follow_target_velocity_law: assertion failed");

// Implication from ante to cons, sampled on clk, off while rst_n is low.
`define FVL_ASSERT_IMPL(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> cons) \
        else $error("follow_target_velocity_law: implication failed");

`else

`define FVL_ASSERT(label, prop)
`define FVL_ASSERT_IMPL(label, ante, cons)

`endif

`endif

@@ hw/rtl/fvl_pkg.sv @@
package fvl_pkg;

    localparam int POS_W      = 16;
    localparam int DIST_W     = 16;
    localparam int SQ_W       = 2 * POS_W;
    localparam int SQRT_STEPS = SQ_W / 2;
    localparam int REM_W      = DIST_W + 1;

    localparam int CORDIC_STEPS = 16;
    localparam int ATAN_ENTRIES = 24;
    localparam int CORDIC_ITERS = (CORDIC_STEPS < ATAN_ENTRIES) ? CORDIC_STEPS : ATAN_ENTRIES;
    localparam int PIPE_ITERS   = (CORDIC_ITERS > SQRT_STEPS) ? CORDIC_ITERS : SQRT_STEPS;
    localparam int CORDIC_SCALE = 16;
    localparam int CW           = 36;
    localparam int Z_W          = 17;
    localparam int ATAN_W       = 14;
    localparam int ANG_W        = 16;
    localparam int HALF_PI_Q14  = 25736;

    localparam logic [ATAN_W-1:0] ATAN_TAB [ATAN_ENTRIES] = '{
        14'd12868, 14'd7596, 14'd4014, 14'd2037, 14'd1023, 14'd512, 14'd256, 14'd128,
        14'd64, 14'd32, 14'd16, 14'd8, 14'd4, 14'd2, 14'd1, 14'd0,
        14'd0, 14'd0, 14'd0, 14'd0, 14'd0, 14'd0, 14'd0, 14'd0
    };

    localparam int GAIN_W = 16;
    localparam int LIM_W  = 15;
    localparam int VAL_W  = 17;
    localparam int VEL_W  = 16;
    localparam int PROD_W = 2 * VAL_W;
    localparam int FRAC_W = 8;

    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 16;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_LIN_GAIN   = 3'd0,
        CFG_LIN_MIN    = 3'd1,
        CFG_LIN_MAX    = 3'd2,
        CFG_ANG_GAIN   = 3'd3,
        CFG_ANG_MIN    = 3'd4,
        CFG_ANG_MAX    = 3'd5,
        CFG_DIST_THR   = 3'd6,
        CFG_ANGLE_THR  = 3'd7
    } cfg_idx_t;

    localparam logic [GAIN_W-1:0] LIN_GAIN_RST  = 16'd256;
    localparam logic [LIM_W-1:0]  LIN_MIN_RST   = 15'd0;
    localparam logic [LIM_W-1:0]  LIN_MAX_RST   = 15'd1024;
    localparam logic [GAIN_W-1:0] ANG_GAIN_RST  = 16'd256;
    localparam logic [LIM_W-1:0]  ANG_MIN_RST   = 15'd0;
    localparam logic [LIM_W-1:0]  ANG_MAX_RST   = 15'd16384;
    localparam logic [DIST_W-1:0] DIST_THR_RST  = 16'd1024;
    localparam logic [LIM_W-1:0]  ANGLE_THR_RST = 15'd1638;

    // input reg, squares, sum, iterations, deadband, product, output
    localparam int FIN_IDX = PIPE_ITERS + 3;
    localparam int LATENCY = PIPE_ITERS + 6;

    typedef struct packed {
        logic signed [VAL_W-1:0] gain;
        logic [LIM_W-1:0]        mn;
        logic [LIM_W-1:0]        mx;
    } lim_cfg_t;

endpackage

@@ hw/rtl/follow_target_velocity_law.sv @@
// Follow target velocity law. Turns a person position (Q5.10 m, base frame) into a
// forward speed and a turn rate. Fully pipelined: busy stays low and an item can be
// started every cycle. A started item with person_present high shows its result on
// linear_vel/angular_vel for one cycle with done high, after the input register, the
// squaring and sum stages, the square root and CORDIC iteration stages (one pipeline
// stage per iteration each), the deadband, product and output registers. An item
// with person_present low is consumed and gives no result. The receiver cannot stall:
// a result is gone after its cycle. Configuration writes are always ready and act at
// once, so write registers only while no item is in flight.
`include "follow_target_velocity_law_defines.svh"

module follow_target_velocity_law (
    input  logic                                  clk,
    input  logic                                  rst_n,
    input  logic                                  start,
    output logic                                  busy,
    input  logic                                  person_present,
    input  logic signed [fvl_pkg::POS_W-1:0]      pos_x,
    input  logic signed [fvl_pkg::POS_W-1:0]      pos_y,
    input  logic                                  cfg_valid,
    output logic                                  cfg_ready,
    input  logic [fvl_pkg::CFG_IDX_W-1:0]         cfg_index,
    input  logic [fvl_pkg::CFG_DATA_W-1:0]        cfg_data,
    output logic                                  done,
    output logic signed [fvl_pkg::VEL_W-1:0]      linear_vel,
    output logic signed [fvl_pkg::VEL_W-1:0]      angular_vel
);
    import fvl_pkg::*;

    logic [GAIN_W-1:0] lin_gain_reg;
    logic [LIM_W-1:0]  lin_min_reg;
    logic [LIM_W-1:0]  lin_max_reg;
    logic [GAIN_W-1:0] ang_gain_reg;
    logic [LIM_W-1:0]  ang_min_reg;
    logic [LIM_W-1:0]  ang_max_reg;
    logic [DIST_W-1:0] dist_thr_reg;
    logic [LIM_W-1:0]  angle_thr_reg;

    logic                     vld_next;
    logic [LATENCY-1:0]       vld_reg;
    logic signed [POS_W-1:0]  x_reg;
    logic signed [POS_W-1:0]  y_reg;

    logic [DIST_W-1:0]        distance;
    logic signed [ANG_W-1:0]  angle;
    logic [ANG_W-1:0]         angle_abs;

    logic [DIST_W-1:0]        dist_reg;
    logic signed [ANG_W-1:0]  angle_reg;
    logic                     lin_en_reg;
    logic                     ang_en_reg;

    lim_cfg_t                 lin_cfg;
    lim_cfg_t                 ang_cfg;
    logic signed [VAL_W-1:0]  lin_value;
    logic signed [VAL_W-1:0]  ang_value;
    logic signed [VAL_W-1:0]  ang_gain_ext;

    assign busy      = 1'b0;
    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            lin_gain_reg  <= LIN_GAIN_RST;
            lin_min_reg   <= LIN_MIN_RST;
            lin_max_reg   <= LIN_MAX_RST;
            ang_gain_reg  <= ANG_GAIN_RST;
            ang_min_reg   <= ANG_MIN_RST;
            ang_max_reg   <= ANG_MAX_RST;
            dist_thr_reg  <= DIST_THR_RST;
            angle_thr_reg <= ANGLE_THR_RST;
        end
        else if (cfg_valid && cfg_ready)
        begin
            unique case (cfg_idx_t'(cfg_index))
                CFG_LIN_GAIN:  lin_gain_reg  <= cfg_data;
                CFG_LIN_MIN:   lin_min_reg   <= cfg_data[LIM_W-1:0];
                CFG_LIN_MAX:   lin_max_reg   <= cfg_data[LIM_W-1:0];
                CFG_ANG_GAIN:  ang_gain_reg  <= cfg_data;
                CFG_ANG_MIN:   ang_min_reg   <= cfg_data[LIM_W-1:0];
                CFG_ANG_MAX:   ang_max_reg   <= cfg_data[LIM_W-1:0];
                CFG_DIST_THR:  dist_thr_reg  <= cfg_data;
                CFG_ANGLE_THR: angle_thr_reg <= cfg_data[LIM_W-1:0];
            endcase
        end
    end

    // valid bits ride alongside the data stages
    assign vld_next = start && !busy && person_present;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            vld_reg <= '0;
        else
            vld_reg <= {vld_reg[LATENCY-2:0], vld_next};
    end

    always_ff @(posedge clk)
    begin
        x_reg <= pos_x;
        y_reg <= pos_y;
    end

    fvl_sqrt_pipe u_sqrt (
        .clk  (clk),
        .x    (x_reg),
        .y    (y_reg),
        .root (distance)
    );

    fvl_cordic_pipe u_cordic (
        .clk   (clk),
        .x     (x_reg),
        .y     (y_reg),
        .angle (angle)
    );

    // deadband decisions
    assign angle_abs = angle[ANG_W-1] ? -angle : angle;

    always_ff @(posedge clk)
    begin
        dist_reg   <= distance;
        angle_reg  <= angle;
        lin_en_reg <= (distance > dist_thr_reg);
        ang_en_reg <= (angle_abs > {1'b0, angle_thr_reg});
    end

    assign ang_gain_ext = {ang_gain_reg[GAIN_W-1], ang_gain_reg};

    assign lin_cfg.gain = {lin_gain_reg[GAIN_W-1], lin_gain_reg};
    assign lin_cfg.mn   = lin_min_reg;
    assign lin_cfg.mx   = lin_max_reg;
    assign ang_cfg.gain = -ang_gain_ext;
    assign ang_cfg.mn   = ang_min_reg;
    assign ang_cfg.mx   = ang_max_reg;

    assign lin_value = {1'b0, dist_reg};
    assign ang_value = {angle_reg[ANG_W-1], angle_reg};

    fvl_gain_limit u_lin (
        .clk   (clk),
        .cfg   (lin_cfg),
        .en    (lin_en_reg),
        .value (lin_value),
        .vel   (linear_vel)
    );

    fvl_gain_limit u_ang (
        .clk   (clk),
        .cfg   (ang_cfg),
        .en    (ang_en_reg),
        .value (ang_value),
        .vel   (angular_vel)
    );

    assign done = vld_reg[LATENCY-1];

    `FVL_ASSERT_IMPL(a_item_latency, start && !busy && person_present, ##LATENCY done)
    `FVL_ASSERT(a_done_from_fin, done |-> $past(vld_reg[FIN_IDX], 2))
    `FVL_ASSERT_IMPL(a_lin_deadband, vld_reg[FIN_IDX] && !lin_en_reg, ##2 (linear_vel == '0))
    `FVL_ASSERT_IMPL(a_ang_deadband, vld_reg[FIN_IDX] && !ang_en_reg, ##2 (angular_vel == '0))

endmodule

@@ hw/rtl/fvl_sqrt_pipe.sv @@
module fvl_sqrt_pipe (
    input  logic                             clk,
    input  logic signed [fvl_pkg::POS_W-1:0] x,
    input  logic signed [fvl_pkg::POS_W-1:0] y,
    output logic [fvl_pkg::DIST_W-1:0]       root
);
    import fvl_pkg::*;

    logic signed [SQ_W-1:0] xsq;
    logic signed [SQ_W-1:0] ysq;
    logic [SQ_W-1:0]        xsq_reg;
    logic [SQ_W-1:0]        ysq_reg;
    logic [SQ_W-1:0]        sum_reg;

    logic [SQ_W-1:0]   rad_reg  [PIPE_ITERS];
    logic [REM_W-1:0]  rem_reg  [PIPE_ITERS];
    logic [DIST_W-1:0] root_reg [PIPE_ITERS];

    assign xsq = x * x;
    assign ysq = y * y;

    always_ff @(posedge clk)
    begin
        xsq_reg <= xsq;
        ysq_reg <= ysq;
        sum_reg <= xsq_reg + ysq_reg;
    end

    // one result bit per stage, two radicand bits consumed each time
    for (genvar k = 0; k < PIPE_ITERS; k++)
    begin : g_stage
        logic [SQ_W-1:0]   rad_in;
        logic [REM_W-1:0]  rem_in;
        logic [DIST_W-1:0] root_in;

        if (k == 0)
        begin : g_first
            assign rad_in  = sum_reg;
            assign rem_in  = '0;
            assign root_in = '0;
        end
        else
        begin : g_next
            assign rad_in  = rad_reg[k-1];
            assign rem_in  = rem_reg[k-1];
            assign root_in = root_reg[k-1];
        end

        if (k < SQRT_STEPS)
        begin : g_step
            logic [REM_W+1:0] rem_sh;
            logic [REM_W+1:0] trial;
            logic [REM_W+1:0] diff;

            assign rem_sh = {rem_in, rad_in[SQ_W-1-2*k -: 2]};
            assign trial  = {{(REM_W-DIST_W){1'b0}}, root_in, 2'b01};
            assign diff   = rem_sh - trial;

            always_ff @(posedge clk)
            begin
                rad_reg[k] <= rad_in;
                if (rem_sh >= trial)
                begin
                    rem_reg[k]  <= diff[REM_W-1:0];
                    root_reg[k] <= {root_in[DIST_W-2:0], 1'b1};
                end
                else
                begin
                    rem_reg[k]  <= rem_sh[REM_W-1:0];
                    root_reg[k] <= {root_in[DIST_W-2:0], 1'b0};
                end
            end
        end
        else
        begin : g_hold
            always_ff @(posedge clk)
            begin
                rad_reg[k]  <= rad_in;
                rem_reg[k]  <= rem_in;
                root_reg[k] <= root_in;
            end
        end
    end

    assign root = root_reg[PIPE_ITERS-1];

endmodule

@@ hw/rtl/fvl_cordic_pipe.sv @@
module fvl_cordic_pipe (
    input  logic                             clk,
    input  logic signed [fvl_pkg::POS_W-1:0] x,
    input  logic signed [fvl_pkg::POS_W-1:0] y,
    output logic signed [fvl_pkg::ANG_W-1:0] angle
);
    import fvl_pkg::*;

    localparam logic signed [Z_W-1:0] Z_HI = Z_W'(HALF_PI_Q14);
    localparam logic signed [Z_W-1:0] Z_LO = -Z_HI;

    logic signed [POS_W:0] xe;
    logic signed [POS_W:0] ye;
    logic signed [POS_W:0] ax_reg;
    logic signed [POS_W:0] ay_reg;
    logic                  zero1_reg;
    logic signed [CW-1:0]  cx0_reg;
    logic signed [CW-1:0]  cy0_reg;
    logic                  zero2_reg;

    logic signed [CW-1:0]  cx_reg   [PIPE_ITERS];
    logic signed [CW-1:0]  cy_reg   [PIPE_ITERS];
    logic signed [Z_W-1:0] z_reg    [PIPE_ITERS];
    logic                  zero_reg [PIPE_ITERS];

    logic signed [Z_W-1:0] z_fin;

    assign xe = {x[POS_W-1], x};
    assign ye = {y[POS_W-1], y};

    // mirror through the origin for x < 0
    always_ff @(posedge clk)
    begin
        ax_reg    <= x[POS_W-1] ? -xe : xe;
        ay_reg    <= x[POS_W-1] ? -ye : ye;
        zero1_reg <= (x == '0);
        cx0_reg   <= {{(CW-POS_W-1-CORDIC_SCALE){ax_reg[POS_W]}}, ax_reg,
                      {CORDIC_SCALE{1'b0}}};
        cy0_reg   <= {{(CW-POS_W-1-CORDIC_SCALE){ay_reg[POS_W]}}, ay_reg,
                      {CORDIC_SCALE{1'b0}}};
        zero2_reg <= zero1_reg;
    end

    for (genvar k = 0; k < PIPE_ITERS; k++)
    begin : g_stage
        logic signed [CW-1:0]  cx_in;
        logic signed [CW-1:0]  cy_in;
        logic signed [Z_W-1:0] z_in;
        logic                  zero_in;

        if (k == 0)
        begin : g_first
            assign cx_in   = cx0_reg;
            assign cy_in   = cy0_reg;
            assign z_in    = '0;
            assign zero_in = zero2_reg;
        end
        else
        begin : g_next
            assign cx_in   = cx_reg[k-1];
            assign cy_in   = cy_reg[k-1];
            assign z_in    = z_reg[k-1];
            assign zero_in = zero_reg[k-1];
        end

        if (k < CORDIC_ITERS)
        begin : g_step
            logic signed [CW-1:0]  dx;
            logic signed [CW-1:0]  dy;
            logic signed [Z_W-1:0] at;

            assign dx = cy_in >>> k;
            assign dy = cx_in >>> k;
            assign at = {{(Z_W-ATAN_W){1'b0}}, ATAN_TAB[k]};

            always_ff @(posedge clk)
            begin
                zero_reg[k] <= zero_in;
                if (!cy_in[CW-1])
                begin
                    cx_reg[k] <= cx_in + dx;
                    cy_reg[k] <= cy_in - dy;
                    z_reg[k]  <= z_in + at;
                end
                else
                begin
                    cx_reg[k] <= cx_in - dx;
                    cy_reg[k] <= cy_in + dy;
                    z_reg[k]  <= z_in - at;
                end
            end
        end
        else
        begin : g_hold
            always_ff @(posedge clk)
            begin
                cx_reg[k]   <= cx_in;
                cy_reg[k]   <= cy_in;
                z_reg[k]    <= z_in;
                zero_reg[k] <= zero_in;
            end
        end
    end

    always_comb
    begin
        z_fin = z_reg[PIPE_ITERS-1];
        if (zero_reg[PIPE_ITERS-1])
            z_fin = '0;
        else if (z_fin > Z_HI)
            z_fin = Z_HI;
        else if (z_fin < Z_LO)
            z_fin = Z_LO;
    end

    assign angle = z_fin[ANG_W-1:0];

endmodule

@@ hw/rtl/fvl_gain_limit.sv @@
module fvl_gain_limit (
    input  logic                             clk,
    input  fvl_pkg::lim_cfg_t                cfg,
    input  logic                             en,
    input  logic signed [fvl_pkg::VAL_W-1:0] value,
    output logic signed [fvl_pkg::VEL_W-1:0] vel
);
    import fvl_pkg::*;

    localparam int G_W = PROD_W - FRAC_W;
    localparam logic signed [PROD_W-1:0] RND = PROD_W'(1 << (FRAC_W - 1));

    logic signed [PROD_W-1:0] prod;
    logic signed [PROD_W-1:0] prod_reg;
    logic                     en_reg;
    logic signed [PROD_W-1:0] rnd;
    logic signed [G_W-1:0]    g;
    logic [G_W-1:0]           mag;
    logic [G_W-1:0]           mn_ext;
    logic [G_W-1:0]           mx_ext;
    logic                     pos;
    logic signed [VEL_W-1:0]  mn_s;
    logic signed [VEL_W-1:0]  mx_s;
    logic signed [VEL_W-1:0]  vel_next;
    logic signed [VEL_W-1:0]  vel_reg;

    assign prod = $signed(cfg.gain) * value;

    always_ff @(posedge clk)
    begin
        prod_reg <= prod;
        en_reg   <= en;
    end

    // round to nearest, ties up, then limit the magnitude; zero when en is low
    assign rnd    = prod_reg + RND;
    assign g      = rnd[PROD_W-1:FRAC_W];
    assign mag    = g[G_W-1] ? -g : g;
    assign mn_ext = {{(G_W-LIM_W){1'b0}}, cfg.mn};
    assign mx_ext = {{(G_W-LIM_W){1'b0}}, cfg.mx};
    assign pos    = !g[G_W-1] && (g != '0);
    assign mn_s   = {1'b0, cfg.mn};
    assign mx_s   = {1'b0, cfg.mx};

    always_comb
    begin
        if (!en_reg)
            vel_next = '0;
        else if (mag < mn_ext)
            vel_next = pos ? mn_s : -mn_s;
        else if (mag > mx_ext)
            vel_next = pos ? mx_s : -mx_s;
        else
            vel_next = g[VEL_W-1:0];
    end

    always_ff @(posedge clk)
    begin
        vel_reg <= vel_next;
    end

    assign vel = vel_reg;

endmodule
